/* rtl/core/rshs_pkg.sv */
package rshs_pkg;

  // Default sizes for the top-level parameters
  localparam int PHASE_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 24;
  localparam int DELAY_BITS_DEF = 20;

  // Fixed field and register widths
  localparam int SAMPLE_W    = 24;
  localparam int INC_W       = 32;
  localparam int DELAY_REG_W = 20;
  localparam int HOLD_W      = 16;
  localparam int HSI_W       = 22;
  localparam int SMOOTH_W    = 17;
  localparam int SEED_W      = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int Q16_W       = 17;  // Q1.16 values that may reach 1.0

  // Register reset values
  localparam logic [INC_W-1:0]    PHASE_INC_RST = 32'd3579139;
  localparam logic [HSI_W-1:0]    HSI_RST       = 22'd65536;
  localparam logic [SEED_W-1:0]   SEED_RST      = 32'd1;

  // Saturation limits and fixed-point one
  localparam logic [HOLD_W-1:0]   HOLD_MAX   = 16'd64225;
  localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 17'd65536;
  localparam logic [Q16_W-1:0]    ONE_Q16    = 17'd65536;
  localparam logic [Q16_W:0]      THREE_Q16  = 18'd196608;

  // Radix-4 shift-add multiplier: signed multiplicand, unsigned multiplier
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 22;
  localparam int MUL_DIGITS = MUL_B_W / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
  localparam int MUL_HI_W   = MUL_A_W + 3;
  localparam int MUL_P_W    = MUL_HI_W + MUL_B_W;
  localparam int T_LSB      = 32;  // t = (diff * hold_span_inverse) >> 32
  localparam int Q16_LSB    = 16;

  // xorshift32 shift amounts
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PHASE_INC = 3'd0,
    REG_DELAY     = 3'd1,
    REG_HOLD      = 3'd2,
    REG_HSI       = 3'd3,
    REG_SMOOTH    = 3'd4,
    REG_SEED      = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED1,
    S_SEED2,
    S_ADVANCE,
    S_CHECK,
    S_MUL,
    S_NEXT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_T,
    OP_T2,
    OP_EASE,
    OP_FACTOR,
    OP_STEP
  } op_t;

  function automatic logic [SEED_W-1:0] xs32_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

endpackage

/* rtl/core/random_sample_hold_smoother.sv */
// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   in_tdata[0] freeze
// out_      out  out_tvalid/out_tready out_tdata[23:0] sample_out, out_tuser[0] in_delay
// cfg_      in   cfg_valid/cfg_ready   cfg_index register, cfg_data value
//
// Per item, a freeze or delay item goes from S_IDLE straight to S_EMIT; a
// generating item steps through S_ADVANCE and S_CHECK, the first one after
// S_SEED1 and S_SEED2. A glide output then runs the one radix-4 shift-add
// multiplier: five products of 11 digits each, each followed by S_NEXT.
// Reset (rst_n low, synchronous) loads register defaults and clears state.
// The output register holds a result while the next item is accepted; a
// stalled output holds only the item that is ready to leave.
module random_sample_hold_smoother
  import rshs_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [0] freeze
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [SAMPLE_W-1:0]    out_tdata,  // [23:0] sample_out
  output logic                   out_tuser,  // [0] in_delay
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int VB   = VALUE_BITS;
  localparam int PB   = PHASE_BITS;
  localparam int DCMP = (DELAY_BITS > DELAY_REG_W) ? DELAY_BITS : DELAY_REG_W;
  localparam logic [DCMP-1:0] DELAY_LIMIT = DCMP'((64'd1 << DELAY_BITS) - 64'd1);

  // Control and configuration
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [MUL_CNT_W-1:0] dig_r, dig_nxt;
  logic [INC_W-1:0]    inc_r, inc_nxt;
  logic [DELAY_REG_W-1:0] delay_r, delay_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  logic [HSI_W-1:0]    hsi_r, hsi_nxt;
  logic [SMOOTH_W-1:0] smooth_r, smooth_nxt;

  // Generator state
  logic [SEED_W-1:0]    prng_r, prng_nxt;
  logic [PB-1:0]        phase_r, phase_nxt;
  logic signed [VB-1:0] held_r, held_nxt;
  logic signed [VB-1:0] up_r, up_nxt;
  logic signed [VB-1:0] last_r, last_nxt;
  logic [DELAY_BITS-1:0] count_r, count_nxt;
  logic                 started_r, started_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Payload registers
  logic [Q16_W-1:0]        t_r, t_nxt;
  logic signed [MUL_A_W-1:0]  mul_a_r, mul_a_nxt;
  logic signed [MUL_HI_W-1:0] mul_hi_r, mul_hi_nxt;
  logic [MUL_B_W-1:0]      mul_lo_r, mul_lo_nxt;
  logic signed [VB-1:0]    result_r, result_nxt;
  logic                    dly_r, dly_nxt;
  logic [SAMPLE_W-1:0]     out_data_r, out_data_nxt;
  logic                    out_user_r, out_user_nxt;

  // Combinational helpers
  logic                  in_acc, cfg_acc, freeze, delaying, out_free, glide_on;
  logic [DCMP-1:0]       delay_lim;
  logic [SEED_W-1:0]     prng_step;
  logic signed [VB-1:0]  draw_val;
  logic [PB+INC_W-1:0]   inc_ext;
  logic [PB-1:0]         inc_ph, hold_ph, diff;
  logic [PB:0]           phase_sum;
  logic [PB+31:0]        diff_ext;
  logic [31:0]           diff32;
  logic [HOLD_W-1:0]     hold_sat;
  logic [SMOOTH_W-1:0]   smooth_sat;
  logic signed [VB:0]    span;
  logic [1:0]            digit;
  logic signed [MUL_HI_W-1:0] a_ext, mul_pa, mul_sum;
  logic signed [MUL_P_W-1:0]  mul_prod;
  logic [MUL_B_W-1:0]    t_raw;
  logic [Q16_W-1:0]      t_sat, q16_val;
  logic signed [VB+1:0]  step_v, glide_sum;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign freeze    = in_tdata[0];
  assign out_free  = !out_valid_r || out_tready;

  assign delay_lim = (DCMP'(delay_r) > DELAY_LIMIT) ? DELAY_LIMIT : DCMP'(delay_r);
  assign delaying  = DCMP'(count_r) < delay_lim;

  // Generator word to signed value: top bits as offset binary
  assign prng_step = xs32_next(prng_r);
  assign draw_val  = {~prng_step[31], prng_step[30 -: VB-1]};

  // Q0.32 increment rescaled to the phase width
  assign inc_ext   = {inc_r, {PB{1'b0}}};
  assign inc_ph    = inc_ext[INC_W +: PB];
  assign phase_sum = {1'b0, phase_r} + {1'b0, inc_ph};

  assign hold_sat   = (hold_r > HOLD_MAX) ? HOLD_MAX : hold_r;
  assign smooth_sat = (smooth_r > SMOOTH_MAX) ? SMOOTH_MAX : smooth_r;
  assign hold_ph    = PB'(hold_sat) << (PB - HOLD_W);
  assign glide_on   = (smooth_sat != '0) && (phase_r > hold_ph);

  // Phase past the hold point, rescaled to Q0.32
  assign diff     = phase_r - hold_ph;
  assign diff_ext = {diff, 32'd0};
  assign diff32   = diff_ext[PB +: 32];

  assign span = {up_r[VB-1], up_r} - {held_r[VB-1], held_r};

  // One radix-4 digit of the shift-add multiplier
  assign digit    = mul_lo_r[1:0];
  assign a_ext    = MUL_HI_W'(mul_a_r);
  assign mul_pa   = (digit[0] ? a_ext : '0) + (digit[1] ? (a_ext <<< 1) : '0);
  assign mul_sum  = mul_hi_r + mul_pa;
  assign mul_prod = {mul_hi_r, mul_lo_r};

  // Product slices
  assign t_raw     = mul_prod[T_LSB +: MUL_B_W];
  assign t_sat     = (t_raw > MUL_B_W'(ONE_Q16)) ? ONE_Q16 : t_raw[Q16_W-1:0];
  assign q16_val   = mul_prod[Q16_LSB +: Q16_W];
  assign step_v    = mul_prod[Q16_LSB +: VB+2];
  assign glide_sum = {held_r[VB-1], held_r[VB-1], held_r} + step_v;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (freeze || delaying) state_nxt = S_EMIT;
          else if (!started_r)    state_nxt = S_SEED1;
          else                    state_nxt = S_ADVANCE;
        end
      end
      S_SEED1:   state_nxt = S_SEED2;
      S_SEED2:   state_nxt = S_ADVANCE;
      S_ADVANCE: state_nxt = S_CHECK;
      S_CHECK:   state_nxt = glide_on ? S_MUL : S_EMIT;
      S_MUL: begin
        if (dig_r == MUL_CNT_W'(MUL_DIGITS - 1)) state_nxt = S_NEXT;
      end
      S_NEXT:    state_nxt = (op_r == OP_STEP) ? S_EMIT : S_MUL;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    dig_nxt       = '0;
    inc_nxt       = inc_r;
    delay_nxt     = delay_r;
    hold_nxt      = hold_r;
    hsi_nxt       = hsi_r;
    smooth_nxt    = smooth_r;
    prng_nxt      = prng_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    up_nxt        = up_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    started_nxt   = started_r;
    t_nxt         = t_r;
    mul_a_nxt     = mul_a_r;
    mul_hi_nxt    = mul_hi_r;
    mul_lo_nxt    = mul_lo_r;
    result_nxt    = result_r;
    dly_nxt       = dly_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (freeze) begin
            // repeat without advancing anything
            result_nxt = last_r;
            dly_nxt    = delaying;
          end else if (delaying) begin
            count_nxt  = count_r + DELAY_BITS'(1);
            last_nxt   = '0;
            result_nxt = '0;
            dly_nxt    = 1'b1;
          end else begin
            dly_nxt    = 1'b0;
          end
        end
      end
      S_SEED1: begin
        prng_nxt = prng_step;
        held_nxt = draw_val;
      end
      S_SEED2: begin
        prng_nxt    = prng_step;
        up_nxt      = draw_val;
        phase_nxt   = '0;
        started_nxt = 1'b1;
      end
      S_ADVANCE: begin
        phase_nxt = phase_sum[PB-1:0];
        if (phase_sum[PB]) begin
          // wrap: shift upcoming into held, draw a fresh upcoming
          held_nxt = up_r;
          up_nxt   = draw_val;
          prng_nxt = prng_step;
        end
      end
      S_CHECK: begin
        if (glide_on) begin
          op_nxt     = OP_T;
          mul_a_nxt  = MUL_A_W'(diff32);
          mul_hi_nxt = '0;
          mul_lo_nxt = hsi_r;
        end else begin
          result_nxt = held_r;
          last_nxt   = held_r;
        end
      end
      S_MUL: begin
        dig_nxt    = dig_r + MUL_CNT_W'(1);
        if (dig_r == MUL_CNT_W'(MUL_DIGITS - 1)) dig_nxt = '0;
        mul_hi_nxt = mul_sum >>> 2;
        mul_lo_nxt = {mul_sum[1:0], mul_lo_r[MUL_B_W-1:2]};
      end
      S_NEXT: begin
        mul_hi_nxt = '0;
        unique case (op_r)
          OP_T: begin
            t_nxt      = t_sat;
            mul_a_nxt  = MUL_A_W'(t_sat);
            mul_lo_nxt = MUL_B_W'(t_sat);
            op_nxt     = OP_T2;
          end
          OP_T2: begin
            // smoothstep: t^2 * (3 - 2t)
            mul_a_nxt  = MUL_A_W'(q16_val);
            mul_lo_nxt = MUL_B_W'(THREE_Q16 - {t_r, 1'b0});
            op_nxt     = OP_EASE;
          end
          OP_EASE: begin
            mul_a_nxt  = MUL_A_W'(q16_val);
            mul_lo_nxt = MUL_B_W'(smooth_sat);
            op_nxt     = OP_FACTOR;
          end
          OP_FACTOR: begin
            mul_a_nxt  = MUL_A_W'(span);
            mul_lo_nxt = MUL_B_W'(q16_val);
            op_nxt     = OP_STEP;
          end
          OP_STEP: begin
            // arithmetic shift floors toward minus infinity
            result_nxt = glide_sum[VB-1:0];
            last_nxt   = glide_sum[VB-1:0];
          end
          default: op_nxt = OP_T;
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          out_data_nxt  = SAMPLE_W'(result_r) << (SAMPLE_W - VB);
          out_user_nxt  = dly_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // The user must send register writes only while idle; the block does not enforce it
    if (cfg_acc) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_INC: inc_nxt    = cfg_data[INC_W-1:0];
        REG_DELAY:     delay_nxt  = cfg_data[DELAY_REG_W-1:0];
        REG_HOLD:      hold_nxt   = cfg_data[HOLD_W-1:0];
        REG_HSI:       hsi_nxt    = cfg_data[HSI_W-1:0];
        REG_SMOOTH:    smooth_nxt = cfg_data[SMOOTH_W-1:0];
        REG_SEED:      prng_nxt   = (cfg_data[SEED_W-1:0] != '0) ?
                                    cfg_data[SEED_W-1:0] : SEED_RST;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_T;
      dig_r       <= '0;
      inc_r       <= PHASE_INC_RST;
      delay_r     <= '0;
      hold_r      <= '0;
      hsi_r       <= HSI_RST;
      smooth_r    <= '0;
      prng_r      <= SEED_RST;
      phase_r     <= '0;
      held_r      <= '0;
      up_r        <= '0;
      last_r      <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      dig_r       <= dig_nxt;
      inc_r       <= inc_nxt;
      delay_r     <= delay_nxt;
      hold_r      <= hold_nxt;
      hsi_r       <= hsi_nxt;
      smooth_r    <= smooth_nxt;
      prng_r      <= prng_nxt;
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      up_r        <= up_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_hi_r   <= mul_hi_nxt;
    mul_lo_r   <= mul_lo_nxt;
    result_r   <= result_nxt;
    dly_r      <= dly_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Generation, once started, stays started
  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");

  // Digit counter runs only inside a multiply
  a_dig_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MUL) |-> (dig_r == '0))
    else $error("digit counter active outside multiply");

  // A freeze item advances nothing
  a_freeze_still: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && freeze) |=> ($stable(prng_r) && $stable(phase_r) && $stable(count_r)))
    else $error("freeze item changed generator state");

  // Glide output lies between held and upcoming values
  a_glide_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT && op_r == OP_STEP) |=>
      (((result_r >= held_r) && (result_r <= up_r)) ||
       ((result_r <= held_r) && (result_r >= up_r))) && (last_r == result_r))
    else $error("glide value outside held/upcoming range");

endmodule

/* verif/tb_random_sample_hold_smoother.sv */
module tb_random_sample_hold_smoother;
  timeunit 1ns;
  timeprecision 1ps;

  import rshs_pkg::*;

  // Give up after this many cycles in which no channel moves an item
  localparam int STALL_LIMIT = 3000;
  // Let the block finish any work in flight before the verdict
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                in_dly;
  } tick_result_t;

  // One line of the directed stimulus: a register write or a tick
  typedef struct packed {
    logic                  is_cfg;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  frz;
    logic                  pinned;
    tick_result_t          pin;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [0] freeze
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [SAMPLE_W-1:0]    out_tdata;       // [23:0] sample_out
  logic                   out_tuser;       // [0] in_delay
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Travel with each tick item: a hand-typed expectation, when there is one
  logic         tick_pinned = 1'b0;
  tick_result_t pin_result = '0;

  // Hold both sides free of random idling while set
  logic calm = 1'b0;

  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  tick_result_t lfo_expect_q[$];
  script_row_t  script_q[$];

  // Shadow copy of the registers
  logic [INC_W-1:0]       m_inc;
  logic [DELAY_REG_W-1:0] m_delay;
  logic [HOLD_W-1:0]      m_hold;
  logic [HSI_W-1:0]       m_hsi;
  logic [SMOOTH_W-1:0]    m_smooth;
  // Shadow copy of the generator state
  logic [SEED_W-1:0]          m_prng;
  logic [31:0]                m_phase;
  logic signed [SAMPLE_W-1:0] m_held;
  logic signed [SAMPLE_W-1:0] m_upcoming;
  logic signed [SAMPLE_W-1:0] m_last;
  logic [DELAY_REG_W-1:0]     m_dcount;
  logic                       m_started;

  random_sample_hold_smoother dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void clear_lfo();
    m_inc      = PHASE_INC_RST;
    m_delay    = '0;
    m_hold     = '0;
    m_hsi      = HSI_RST;
    m_smooth   = '0;
    m_prng     = SEED_RST;
    m_phase    = '0;
    m_held     = '0;
    m_upcoming = '0;
    m_last     = '0;
    m_dcount   = '0;
    m_started  = 1'b0;
  endfunction

  function automatic void load_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_PHASE_INC: m_inc = d;
      REG_DELAY:     m_delay = d[DELAY_REG_W-1:0];
      REG_HOLD:      m_hold = d[HOLD_W-1:0];
      REG_HSI:       m_hsi = d[HSI_W-1:0];
      REG_SMOOTH:    m_smooth = d[SMOOTH_W-1:0];
      // A zero seed would lock the generator; load one instead
      REG_SEED:      m_prng = (d != '0) ? d : 32'd1;
      default: ;
    endcase
  endfunction

  // Step the xorshift word and map its top bits from offset binary to signed
  function automatic logic signed [SAMPLE_W-1:0] draw_random();
    logic [SEED_W-1:0] x;
    x = m_prng;
    x = x ^ (x << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    m_prng = x;
    return {~x[31], x[30:8]};
  endfunction

  // Ease from held toward upcoming once the phase is past the hold point
  function automatic logic signed [SAMPLE_W-1:0] glide_level();
    longint unsigned hold_c, smooth_c, hold_ph, diff, t, t2, eased, factor;
    longint          span, prod;
    hold_c   = (m_hold > HOLD_MAX) ? HOLD_MAX : m_hold;
    smooth_c = (m_smooth > SMOOTH_MAX) ? SMOOTH_MAX : m_smooth;
    hold_ph  = hold_c << 16;
    if (smooth_c == 0 || m_phase <= hold_ph) begin
      return m_held;
    end
    diff = m_phase - hold_ph;
    t = (diff * m_hsi) >> T_LSB;
    if (t > ONE_Q16) begin
      t = ONE_Q16;
    end
    t2     = (t * t) >> Q16_LSB;
    eased  = (t2 * (THREE_Q16 - 2 * t)) >> Q16_LSB;
    factor = (eased * smooth_c) >> Q16_LSB;
    span   = longint'(m_upcoming) - longint'(m_held);
    prod   = span * longint'(factor);
    // Arithmetic shift rounds toward minus infinity
    return SAMPLE_W'(longint'(m_held) + (prod >>> Q16_LSB));
  endfunction

  function automatic tick_result_t advance_lfo(logic frz);
    tick_result_t r;
    logic [32:0]  next_ph;
    r.in_dly = (m_dcount < m_delay);
    r.sample = m_last;
    if (frz) begin
      return r;
    end
    if (m_dcount < m_delay) begin
      m_dcount++;
      m_last   = '0;
      r.sample = '0;
      return r;
    end
    if (!m_started) begin
      m_held     = draw_random();
      m_upcoming = draw_random();
      m_phase    = '0;
      m_started  = 1'b1;
    end
    next_ph = {1'b0, m_phase} + m_inc;
    if (next_ph[32]) begin
      m_held     = m_upcoming;
      m_upcoming = draw_random();
    end
    m_phase  = next_ph[31:0];
    m_last   = glide_level();
    r.sample = m_last;
    r.in_dly = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor and scoreboard
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h want %h at %0t ns", what, got, want, $time);
    mismatch_count++;
  endtask

  // Sample everything on the pre-edge values, so driver order cannot matter
  always @(posedge clk) begin : monitor
    tick_result_t predicted, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        load_register(cfg_reg_t'(cfg_index), cfg_data);
      end
      if (in_tvalid && in_tready) begin
        // Advance the predictor even where the row carries a typed value
        predicted = advance_lfo(in_tdata[0]);
        lfo_expect_q.push_back(tick_pinned ? pin_result : predicted);
      end
      if (out_tvalid && out_tready) begin
        if (lfo_expect_q.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata, '0);
        end else begin
          want = lfo_expect_q.pop_front();
          if (out_tdata !== want.sample) begin
            report_mismatch("sample_out", out_tdata, want.sample);
          end
          if (out_tuser !== want.in_dly) begin
            report_mismatch("in_delay", out_tuser, want.in_dly);
          end
        end
      end
    end
  end

  // Stall the result side at random, about 28 percent of the time, except when calm
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 28);
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one tick item; leave tvalid high so the next item can follow
  task automatic push_tick(input logic frz, input logic pinned, input tick_result_t pin);
    while (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= {7'b0, frz};
    tick_pinned <= pinned;
    pin_result  <= pin;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and wait until every expected result has come out
  task automatic settle_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (lfo_expect_q.size() != 0);
  endtask

  // Keep cfg_valid high across back-to-back writes
  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) begin
      cfg_valid <= 1'b0;
    end
  endtask

  function automatic script_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic script_row_t tick_row(logic frz);
    script_row_t row;
    row     = '0;
    row.idx = REG_PHASE_INC;
    row.frz = frz;
    return row;
  endfunction

  function automatic script_row_t pinned_row(logic frz, logic [SAMPLE_W-1:0] s, logic d);
    script_row_t row;
    row            = tick_row(frz);
    row.pinned     = 1'b1;
    row.pin.sample = s;
    row.pin.in_dly = d;
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin : stimulus
    script_row_t            row;
    cfg_reg_t               wr_idx[$];
    logic [CFG_DATA_W-1:0]  wr_val[$];
    logic [CFG_DATA_W-1:0]  pick;
    logic [HOLD_W-1:0]      new_hold;
    longint unsigned        inv;
    int                     n;

    clear_lfo();

    // Directed part: reset state, delay handling, register extremes
    script_q.push_back(pinned_row(1'b1, '0, 1'b0));  // freeze before any output
    script_q.push_back(tick_row(1'b0));              // first draw from seed one
    script_q.push_back(tick_row(1'b0));
    script_q.push_back(tick_row(1'b1));
    // Raise the delay after start: generation pauses and outputs zero
    script_q.push_back(cfg_row(REG_DELAY, 32'd3));
    script_q.push_back(pinned_row(1'b0, '0, 1'b1));
    script_q.push_back(pinned_row(1'b1, '0, 1'b1));
    script_q.push_back(pinned_row(1'b0, '0, 1'b1));
    script_q.push_back(pinned_row(1'b0, '0, 1'b1));
    script_q.push_back(tick_row(1'b0));              // resume where it paused
    // Top of every register but the delay: saturated hold and smoothing, zero seed
    script_q.push_back(cfg_row(REG_PHASE_INC, 32'hFFFF_FFFF));
    script_q.push_back(cfg_row(REG_HOLD, 32'h0000_FFFF));
    script_q.push_back(cfg_row(REG_HSI, 32'h003F_FFFF));
    script_q.push_back(cfg_row(REG_SMOOTH, 32'h0001_FFFF));
    script_q.push_back(cfg_row(REG_SEED, 32'h0));
    script_q.push_back(tick_row(1'b0));
    script_q.push_back(tick_row(1'b0));
    script_q.push_back(tick_row(1'b1));
    script_q.push_back(tick_row(1'b0));
    // Bottom: frozen phase, no hold, full glide
    script_q.push_back(cfg_row(REG_PHASE_INC, 32'h0));
    script_q.push_back(cfg_row(REG_HOLD, 32'h0));
    script_q.push_back(cfg_row(REG_SMOOTH, 32'd65536));
    script_q.push_back(cfg_row(REG_HSI, 32'd65536));
    script_q.push_back(tick_row(1'b0));
    script_q.push_back(tick_row(1'b0));
    // Longest delay: only zeros while it runs
    script_q.push_back(cfg_row(REG_DELAY, 32'd1048575));
    script_q.push_back(pinned_row(1'b0, '0, 1'b1));
    script_q.push_back(pinned_row(1'b0, '0, 1'b1));
    // Mid-range glide setting with a fresh seed
    script_q.push_back(cfg_row(REG_DELAY, 32'h0));
    script_q.push_back(cfg_row(REG_PHASE_INC, 32'h1000_0000));
    script_q.push_back(cfg_row(REG_HOLD, 32'd32768));
    script_q.push_back(cfg_row(REG_HSI, 32'd131072));
    script_q.push_back(cfg_row(REG_SMOOTH, 32'd40000));
    script_q.push_back(cfg_row(REG_SEED, 32'h9E37_79B9));
    repeat (5) script_q.push_back(tick_row(1'b0));

    // Hold reset low, then release it once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < script_q.size(); i++) begin
      row = script_q[i];
      if (row.is_cfg) begin
        // Registers change only with nothing in flight
        if (i == 0 || !script_q[i-1].is_cfg) begin
          settle_outputs();
        end
        cfg_write(row.idx, row.val, (i + 1 < script_q.size()) && script_q[i+1].is_cfg);
      end else begin
        push_tick(row.frz, row.pinned, row.pin);
      end
    end

    // Random part: phases of ticks, each under a fresh register setting
    for (int phase_no = 0; phase_no < 14; phase_no++) begin
      settle_outputs();
      // Run two phases with no idling on either side
      calm <= (phase_no == 6 || phase_no == 7);
      wr_idx.delete();
      wr_val.delete();
      new_hold = m_hold;

      if (phase_no == 0 || $urandom_range(99) < 60) begin
        case ($urandom_range(0, 5))
          0:       pick = 32'hFFFF_FFFF;
          1:       pick = 32'h0;
          2:       pick = $urandom;
          default: pick = 32'hFFFF_FFFF / $urandom_range(2, 40);  // wrap every few ticks
        endcase
        wr_idx.push_back(REG_PHASE_INC);
        wr_val.push_back(pick);
      end
      if (phase_no == 0 || $urandom_range(99) < 40) begin
        // Keep the delay near the running count so pauses stay short
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: pick = 32'h0;
          5, 6, 7:       pick = m_dcount + $urandom_range(1, 12);
          default:       pick = $urandom_range(0, 30);
        endcase
        wr_idx.push_back(REG_DELAY);
        wr_val.push_back(pick);
      end
      if (phase_no == 0 || $urandom_range(99) < 60) begin
        case ($urandom_range(0, 5))
          0:       new_hold = '0;
          1:       new_hold = HOLD_MAX;
          2:       new_hold = 16'hFFFF;
          default: new_hold = $urandom_range(0, 65535);
        endcase
        wr_idx.push_back(REG_HOLD);
        wr_val.push_back(new_hold);
      end
      if (phase_no == 0 || $urandom_range(99) < 60) begin
        inv = 64'h1_0000_0000 / (64'd65536 - new_hold);
        case ($urandom_range(0, 5))
          0:       pick = 32'h0;
          1:       pick = 32'h003F_FFFF;
          2:       pick = $urandom_range(65536, 3276800);
          default: pick = (inv > 64'h3F_FFFF) ? 32'h003F_FFFF : inv[31:0];  // matches hold
        endcase
        wr_idx.push_back(REG_HSI);
        wr_val.push_back(pick);
      end
      if (phase_no == 0 || $urandom_range(99) < 60) begin
        case ($urandom_range(0, 4))
          0:       pick = 32'h0;
          1:       pick = 32'd65536;
          2:       pick = 32'h0001_FFFF;
          default: pick = $urandom_range(0, 131071);
        endcase
        wr_idx.push_back(REG_SMOOTH);
        wr_val.push_back(pick);
      end
      if (phase_no == 0 || $urandom_range(99) < 30) begin
        pick = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
        wr_idx.push_back(REG_SEED);
        wr_val.push_back(pick);
      end

      for (int k = 0; k < wr_idx.size(); k++) begin
        cfg_write(wr_idx[k], wr_val[k], k + 1 < wr_idx.size());
      end

      n = $urandom_range(80, 100);
      repeat (n) push_tick($urandom_range(99) < 15, 1'b0, '0);
    end

    // Drain, then let anything still in flight show up
    settle_outputs();
    calm <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
